// File: design/lfu_pkg.sv
// Shared types and constants for the LFU page replacement block.
// Used by lfu_cell and lfu_page_replacement; no dependencies.
package lfu_pkg;

  localparam int PAGE_W     = 16;
  localparam int STAMP_W    = 32;
  localparam int FAULT_W    = 32;
  localparam int OUT_SLOT_W = 4;
  localparam int CFG_W      = 5;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Control flags carried by the lookup request as it walks the cell row.
  typedef struct packed {
    logic vld;       // a request occupies this stage
    logic hit;       // some earlier cell matched the page
    logic best_vld;  // an eviction candidate has been chosen
    logic best_res;  // the chosen candidate holds a resident page
  } probe_flags_t;

  // Update broadcast from the controller to the cells.
  typedef struct packed {
    logic load;  // load a new page into the addressed cell
    logic bump;  // raise the use count of the addressed cell
  } upd_t;

endpackage

// File: design/lfu_page_replacement.sv
// Top level of the LFU page replacement block: request controller, row of
// lfu_cell frames and the result register. Depends on lfu_pkg and lfu_cell.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   in       | in_valid_i / in_stall_o      | page_number_i
//   out      | out_valid_o / out_stall_i    | hit_o, frame_slot_o,
//            |                              | evicted_valid_o, evicted_page_o,
//            |                              | fault_total_o
//   config   | frames_in_use_we_i           | frames_in_use_i
//
// A request walks the row of FRAME_COUNT cells, one cell per cycle; the
// captured end of the walk is then committed to the result register, and
// the next request can be taken once the controller is back in idle.
// One request is in flight at a time; in_stall_o is high while it is.
// A finished result waits in the output register while out_stall_i is high;
// the request behind it may already be scanning. Reset clears all frames.
module lfu_page_replacement #(
  parameter int FRAME_COUNT = 16,
  parameter int USE_WIDTH   = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             frames_in_use_we_i,
  input  logic [lfu_pkg::CFG_W-1:0]        frames_in_use_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lfu_pkg::PAGE_W-1:0]       page_number_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             hit_o,
  output logic [lfu_pkg::OUT_SLOT_W-1:0]   frame_slot_o,
  output logic                             evicted_valid_o,
  output logic [lfu_pkg::PAGE_W-1:0]       evicted_page_o,
  output logic [lfu_pkg::FAULT_W-1:0]      fault_total_o
);

  localparam int SLOT_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
  localparam int CNT_W  = $clog2(FRAME_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [lfu_pkg::CFG_W-1:0]   frames_in_use_q;
  logic [CNT_W-1:0]            m;
  logic [CNT_W-1:0]            filled_q;
  logic [lfu_pkg::STAMP_W-1:0] stamp_q;
  logic [lfu_pkg::FAULT_W-1:0] fault_q;

  lfu_pkg::probe_flags_t       launch_q;
  logic [lfu_pkg::PAGE_W-1:0]  launch_page_q;

  lfu_pkg::probe_flags_t       flags_w      [FRAME_COUNT+1];
  logic [lfu_pkg::PAGE_W-1:0]  page_w       [FRAME_COUNT+1];
  logic [SLOT_W-1:0]           hit_slot_w   [FRAME_COUNT+1];
  logic [SLOT_W-1:0]           best_slot_w  [FRAME_COUNT+1];
  logic [USE_WIDTH-1:0]        best_uses_w  [FRAME_COUNT+1];
  logic [lfu_pkg::STAMP_W-1:0] best_stamp_w [FRAME_COUNT+1];
  logic [lfu_pkg::PAGE_W-1:0]  best_page_w  [FRAME_COUNT+1];

  lfu_pkg::probe_flags_t       cap_flags_q;
  logic [lfu_pkg::PAGE_W-1:0]  cap_page_q;
  logic [SLOT_W-1:0]           cap_hit_slot_q;
  logic [SLOT_W-1:0]           cap_best_slot_q;
  logic [lfu_pkg::PAGE_W-1:0]  cap_best_page_q;

  lfu_pkg::upd_t               upd;
  logic [SLOT_W-1:0]           upd_slot;
  logic                        accept;
  logic                        commit;
  logic                        fill;
  logic                        ev_vld;
  logic [lfu_pkg::PAGE_W-1:0]  ev_page;

  logic                        out_vld_q;
  logic                        hit_q;
  logic [lfu_pkg::OUT_SLOT_W-1:0] slot_q;
  logic                        ev_vld_q;
  logic [lfu_pkg::PAGE_W-1:0]  ev_page_q;

  // Managed frame count: zero means one, anything above the row length
  // means the whole row.
  always_comb begin
    if (frames_in_use_q == '0) begin
      m = CNT_W'(1);
    end else if (32'(frames_in_use_q) > FRAME_COUNT) begin
      m = CNT_W'(FRAME_COUNT);
    end else begin
      m = CNT_W'(frames_in_use_q);
    end
  end

  assign accept = in_valid_i && (state_q == ST_IDLE);
  assign commit = (state_q == ST_COMMIT) && (!out_vld_q || !out_stall_i);
  assign fill   = filled_q < m;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (flags_w[FRAME_COUNT].vld) state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Decide what the finished lookup does to the table.
  always_comb begin
    upd      = '0;
    upd_slot = cap_best_slot_q;
    ev_vld   = 1'b0;
    ev_page  = '0;
    if (cap_flags_q.hit) begin
      upd.bump = commit;
      upd_slot = cap_hit_slot_q;
    end else if (fill) begin
      upd.load = commit;
      upd_slot = SLOT_W'(filled_q);
    end else begin
      upd.load = commit;
      ev_vld   = cap_flags_q.best_res;
      ev_page  = cap_flags_q.best_res ? cap_best_page_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      frames_in_use_q <= lfu_pkg::CFG_RESET;
      filled_q        <= '0;
      stamp_q         <= lfu_pkg::STAMP_W'(1);
      fault_q         <= '0;
      launch_q        <= '0;
      cap_flags_q     <= '0;
      out_vld_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (frames_in_use_we_i) begin
        frames_in_use_q <= frames_in_use_i;
      end
      launch_q <= '{vld: accept, default: 1'b0};
      if ((state_q == ST_SCAN) && flags_w[FRAME_COUNT].vld) begin
        cap_flags_q <= flags_w[FRAME_COUNT];
      end
      if (commit && !cap_flags_q.hit) begin
        if (fill) filled_q <= filled_q + CNT_W'(1);
        stamp_q <= stamp_q + lfu_pkg::STAMP_W'(1);
        if (fault_q != '1) fault_q <= fault_q + lfu_pkg::FAULT_W'(1);
      end
      if (commit) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      launch_page_q <= page_number_i;
    end
    if ((state_q == ST_SCAN) && flags_w[FRAME_COUNT].vld) begin
      cap_page_q      <= page_w[FRAME_COUNT];
      cap_hit_slot_q  <= hit_slot_w[FRAME_COUNT];
      cap_best_slot_q <= best_slot_w[FRAME_COUNT];
      cap_best_page_q <= best_page_w[FRAME_COUNT];
    end
    if (commit) begin
      hit_q     <= cap_flags_q.hit;
      slot_q    <= lfu_pkg::OUT_SLOT_W'(upd_slot);
      ev_vld_q  <= ev_vld;
      ev_page_q <= ev_page;
    end
  end

  assign flags_w[0]      = launch_q;
  assign page_w[0]       = launch_page_q;
  assign hit_slot_w[0]   = '0;
  assign best_slot_w[0]  = '0;
  assign best_uses_w[0]  = '0;
  assign best_stamp_w[0] = '0;
  assign best_page_w[0]  = '0;

  for (genvar i = 0; i < FRAME_COUNT; i++) begin : g_cell
    lfu_cell #(
      .USE_WIDTH (USE_WIDTH),
      .IDX       (i),
      .SLOT_W    (SLOT_W),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .m_i          (m),
      .flags_i      (flags_w[i]),
      .page_i       (page_w[i]),
      .hit_slot_i   (hit_slot_w[i]),
      .best_slot_i  (best_slot_w[i]),
      .best_uses_i  (best_uses_w[i]),
      .best_stamp_i (best_stamp_w[i]),
      .best_page_i  (best_page_w[i]),
      .flags_o      (flags_w[i+1]),
      .page_o       (page_w[i+1]),
      .hit_slot_o   (hit_slot_w[i+1]),
      .best_slot_o  (best_slot_w[i+1]),
      .best_uses_o  (best_uses_w[i+1]),
      .best_stamp_o (best_stamp_w[i+1]),
      .best_page_o  (best_page_w[i+1]),
      .upd_i        (upd),
      .upd_slot_i   (upd_slot),
      .upd_page_i   (cap_page_q),
      .upd_stamp_i  (stamp_q)
    );
  end

  assign in_stall_o      = (state_q != ST_IDLE);
  assign out_valid_o     = out_vld_q;
  assign hit_o           = hit_q;
  assign frame_slot_o    = slot_q;
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_total_o   = fault_q;

  // The fault counter moves at the same edge that loads the result register,
  // so a shown result already includes its own fault.
endmodule

// File: design/lfu_cell.sv
// One frame of the LFU table: holds valid, page, use count and load stamp,
// and forwards the lookup request to its neighbor one stage per cycle.
// Depends on lfu_pkg.
module lfu_cell #(
  parameter int USE_WIDTH = 16,
  parameter int IDX       = 0,
  parameter int SLOT_W    = 4,
  parameter int CNT_W     = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [CNT_W-1:0]            m_i,
  input  lfu_pkg::probe_flags_t       flags_i,
  input  logic [lfu_pkg::PAGE_W-1:0]  page_i,
  input  logic [SLOT_W-1:0]           hit_slot_i,
  input  logic [SLOT_W-1:0]           best_slot_i,
  input  logic [USE_WIDTH-1:0]        best_uses_i,
  input  logic [lfu_pkg::STAMP_W-1:0] best_stamp_i,
  input  logic [lfu_pkg::PAGE_W-1:0]  best_page_i,
  output lfu_pkg::probe_flags_t       flags_o,
  output logic [lfu_pkg::PAGE_W-1:0]  page_o,
  output logic [SLOT_W-1:0]           hit_slot_o,
  output logic [SLOT_W-1:0]           best_slot_o,
  output logic [USE_WIDTH-1:0]        best_uses_o,
  output logic [lfu_pkg::STAMP_W-1:0] best_stamp_o,
  output logic [lfu_pkg::PAGE_W-1:0]  best_page_o,
  input  lfu_pkg::upd_t               upd_i,
  input  logic [SLOT_W-1:0]           upd_slot_i,
  input  logic [lfu_pkg::PAGE_W-1:0]  upd_page_i,
  input  logic [lfu_pkg::STAMP_W-1:0] upd_stamp_i
);

  localparam logic [SLOT_W-1:0] MySlot = SLOT_W'(IDX);

  logic                        vld_q;
  logic [lfu_pkg::PAGE_W-1:0]  pg_q;
  logic [USE_WIDTH-1:0]        uses_q;
  logic [lfu_pkg::STAMP_W-1:0] stamp_q;

  lfu_pkg::probe_flags_t       flags_q;
  logic [lfu_pkg::PAGE_W-1:0]  page_q;
  logic [SLOT_W-1:0]           hit_slot_q;
  logic [SLOT_W-1:0]           best_slot_q;
  logic [USE_WIDTH-1:0]        best_uses_q;
  logic [lfu_pkg::STAMP_W-1:0] best_stamp_q;
  logic [lfu_pkg::PAGE_W-1:0]  best_page_q;

  logic active;
  logic match;
  logic better;
  logic addressed;

  assign active = CNT_W'(IDX) < m_i;
  assign match  = flags_i.vld && active && !flags_i.hit && vld_q && (pg_q == page_i);
  // Strictly lower count, or equal count with an older stamp, displaces the
  // candidate; full ties keep the lower slot.
  assign better = flags_i.vld && active &&
                  (!flags_i.best_vld || (uses_q < best_uses_i) ||
                   ((uses_q == best_uses_i) && (stamp_q < best_stamp_i)));
  assign addressed = (upd_slot_i == MySlot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= 1'b0;
      uses_q  <= '0;
      stamp_q <= '0;
      flags_q <= '0;
    end else begin
      flags_q.vld      <= flags_i.vld;
      flags_q.hit      <= flags_i.hit | match;
      flags_q.best_vld <= flags_i.best_vld | better;
      flags_q.best_res <= better ? vld_q : flags_i.best_res;
      if (upd_i.load && addressed) begin
        vld_q   <= 1'b1;
        uses_q  <= USE_WIDTH'(1);
        stamp_q <= upd_stamp_i;
      end else if (upd_i.bump && addressed && (uses_q != '1)) begin
        uses_q <= uses_q + USE_WIDTH'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.load && addressed) begin
      pg_q <= upd_page_i;
    end
    page_q       <= page_i;
    hit_slot_q   <= match ? MySlot : hit_slot_i;
    best_slot_q  <= better ? MySlot : best_slot_i;
    best_uses_q  <= better ? uses_q : best_uses_i;
    best_stamp_q <= better ? stamp_q : best_stamp_i;
    best_page_q  <= better ? pg_q : best_page_i;
  end

  assign flags_o      = flags_q;
  assign page_o       = page_q;
  assign hit_slot_o   = hit_slot_q;
  assign best_slot_o  = best_slot_q;
  assign best_uses_o  = best_uses_q;
  assign best_stamp_o = best_stamp_q;
  assign best_page_o  = best_page_q;

endmodule

// File: design/lfu_checker.sv
// Port-level checks for lfu_page_replacement, attached with a bind.
// Depends on lfu_pkg for field widths.
module lfu_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic                           hit_o,
  input logic [lfu_pkg::OUT_SLOT_W-1:0] frame_slot_o,
  input logic                           evicted_valid_o,
  input logic [lfu_pkg::PAGE_W-1:0]     evicted_page_o,
  input logic [lfu_pkg::FAULT_W-1:0]    fault_total_o
);

  // Only one request is looked up at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while a lookup was in flight");

  // A hit never replaces a page.
  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (!evicted_valid_o && (evicted_page_o == '0)))
    else $error("hit reported an eviction");

  // A fault is already counted when its result is shown.
  a_fault_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !hit_o) |-> (fault_total_o != '0))
    else $error("page fault shown with a zero fault total");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(hit_o) && $stable(frame_slot_o) &&
       $stable(evicted_valid_o) && $stable(evicted_page_o) &&
       $stable(fault_total_o)))
    else $error("stalled result changed");

endmodule

bind lfu_page_replacement lfu_checker u_lfu_checker (.*);
